FILE: rtl/vbs_pkg.sv
package vbs_pkg;

   localparam int NUM_SAMPLES_DEF = 20;
   localparam int MAX_WIDTH_DEF   = 640;
   localparam int MAX_HEIGHT_DEF  = 480;

   localparam int PIX_W   = 8;
   localparam int ROW_W   = 9;
   localparam int COL_W   = 10;
   localparam int SLOT_W  = 5;
   localparam int DIR_W   = 3;
   localparam int MIN_W   = 5;
   localparam int DIM_W   = 13;
   localparam int REQ_W   = 48;
   localparam int RSP_W   = 8;
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   localparam logic [1:0] REG_RADIUS = 2'd0;
   localparam logic [1:0] REG_MIN    = 2'd1;
   localparam logic [1:0] REG_WIDTH  = 2'd2;
   localparam logic [1:0] REG_HEIGHT = 2'd3;

   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

   localparam logic [DIR_W-1:0] DIR_UL = 3'd0;
   localparam logic [DIR_W-1:0] DIR_U  = 3'd1;
   localparam logic [DIR_W-1:0] DIR_UR = 3'd2;
   localparam logic [DIR_W-1:0] DIR_DL = 3'd3;
   localparam logic [DIR_W-1:0] DIR_D  = 3'd4;
   localparam logic [DIR_W-1:0] DIR_DR = 3'd5;
   localparam logic [DIR_W-1:0] DIR_L  = 3'd6;
   localparam logic [DIR_W-1:0] DIR_R  = 3'd7;

   typedef struct packed {
      logic [PIX_W-1:0]  match_radius;
      logic [MIN_W-1:0]  min_matches;
      logic [COL_W-1:0]  image_width;
      logic [ROW_W-1:0]  image_height;
   } cfg_type;

   typedef struct packed {
      logic latch;
      logic calc_addr;
      logic calc_nb;
      logic load_wr;
      logic cmp;
      logic count;
      logic self_wr;
      logic nb_wr;
      logic out_set;
   } ctl_type;

   typedef struct packed {
      logic is_load;
      logic in_frame;
      logic interior;
      logic fg;
      logic self_hit;
      logic nb_hit;
   } sts_type;

endpackage

FILE: rtl/vbs_ram.sv
module vbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/vbs_csr.sv
module vbs_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [vbs_pkg::PADDR_W-1:0]  csr_paddr,
   input  logic [vbs_pkg::PDATA_W-1:0]  csr_pwdata,
   output logic [vbs_pkg::PDATA_W-1:0]  csr_prdata,
   output logic                         csr_pready,
   output vbs_pkg::cfg_type             cfg
);
   import vbs_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr;
   logic [1:0] idx;

   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_RADIUS: cfg_in.match_radius = csr_pwdata[PIX_W-1:0];
            REG_MIN:    cfg_in.min_matches  = csr_pwdata[MIN_W-1:0];
            REG_WIDTH:  cfg_in.image_width  = csr_pwdata[COL_W-1:0];
            REG_HEIGHT: cfg_in.image_height = csr_pwdata[ROW_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_radius <= PIX_W'(20);
         cfg_ff.min_matches  <= MIN_W'(2);
         cfg_ff.image_width  <= COL_W'(640);
         cfg_ff.image_height <= ROW_W'(480);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_RADIUS: csr_prdata = PDATA_W'(cfg_ff.match_radius);
         REG_MIN:    csr_prdata = PDATA_W'(cfg_ff.min_matches);
         REG_WIDTH:  csr_prdata = PDATA_W'(cfg_ff.image_width);
         REG_HEIGHT: csr_prdata = PDATA_W'(cfg_ff.image_height);
         default:    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;
endmodule

FILE: rtl/vbs_ctrl.sv
module vbs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  vbs_pkg::sts_type  sts,
   output vbs_pkg::ctl_type  ctl
);
   import vbs_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ADDR = 4'd1;
   localparam logic [3:0] S_LOAD = 4'd2;
   localparam logic [3:0] S_RD   = 4'd3;
   localparam logic [3:0] S_CMP  = 4'd4;
   localparam logic [3:0] S_CNT  = 4'd5;
   localparam logic [3:0] S_SELF = 4'd6;
   localparam logic [3:0] S_NB   = 4'd7;
   localparam logic [3:0] S_DONE = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.latch = 1'b1;
               state_in  = S_ADDR;
            end
         end
         S_ADDR: begin
            ctl.calc_addr = 1'b1;
            state_in      = S_LOAD;
         end
         S_LOAD: begin
            if (sts.is_load) begin
               ctl.load_wr = sts.in_frame;
               state_in    = S_DONE;
            end else if (sts.interior) begin
               state_in = S_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RD: begin
            ctl.calc_nb = 1'b1;
            state_in    = S_CMP;
         end
         S_CMP: begin
            ctl.cmp  = 1'b1;
            state_in = S_CNT;
         end
         S_CNT: begin
            ctl.count = 1'b1;
            state_in  = S_SELF;
         end
         S_SELF: begin
            ctl.self_wr = !sts.fg && sts.self_hit;
            state_in    = S_NB;
         end
         S_NB: begin
            ctl.nb_wr = !sts.fg && sts.nb_hit;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               ctl.out_set = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.out_set) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff)
      else $error("result beat dropped while stalled");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_ADDR)
      else $error("accepted beat did not start work");
   a_wr: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.load_wr, ctl.self_wr, ctl.nb_wr}))
      else $error("two sample writes in one cycle");
   a_fgwr: assert property (@(posedge clock) disable iff (reset)
      (ctl.self_wr || ctl.nb_wr) |-> !sts.fg && !sts.is_load)
      else $error("update on foreground or load");
endmodule

FILE: rtl/vbs_dp.sv
module vbs_dp #(
   parameter int NUM_SAMPLES = vbs_pkg::NUM_SAMPLES_DEF,
   parameter int MAX_WIDTH   = vbs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = vbs_pkg::MAX_HEIGHT_DEF
) (
   input  logic                       clock,
   input  logic                       req_tuser,
   input  logic [vbs_pkg::REQ_W-1:0]  req_tdata,
   output logic [vbs_pkg::RSP_W-1:0]  rsp_tdata,
   input  vbs_pkg::cfg_type           cfg,
   input  vbs_pkg::ctl_type           ctl,
   output vbs_pkg::sts_type           sts
);
   import vbs_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(NUM_SAMPLES + 1);
   localparam int CMP_W  = (CNT_W > MIN_W) ? CNT_W : MIN_W;

   logic              cmd_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  col_ff;
   logic [PIX_W-1:0]  px_ff;
   logic              self_hit_ff, nb_hit_ff;
   logic [SLOT_W-1:0] self_slot_ff, nb_slot_ff;
   logic [DIR_W-1:0]  dir_ff;
   logic [ADDR_W-1:0] addr_ff, nb_addr_ff, nb_addr_in;
   logic              in_frame_ff, interior_ff, fg_ff, rsp_fg_ff;
   logic [NUM_SAMPLES-1:0] match_ff;
   logic [PIX_W-1:0]  rd [NUM_SAMPLES];
   logic [NUM_SAMPLES-1:0] match_in;
   logic [DIM_W-1:0]  eff_w, eff_h, r_x, c_x;
   logic [CNT_W-1:0]  cnt;
   logic [ADDR_W-1:0] waddr;

   assign eff_w = (DIM_W'(cfg.image_width) < DIM_W'(MAX_WIDTH)) ?
                  DIM_W'(cfg.image_width) : DIM_W'(MAX_WIDTH);
   assign eff_h = (DIM_W'(cfg.image_height) < DIM_W'(MAX_HEIGHT)) ?
                  DIM_W'(cfg.image_height) : DIM_W'(MAX_HEIGHT);
   assign r_x   = DIM_W'(row_ff);
   assign c_x   = DIM_W'(col_ff);

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff       <= req_tuser;
         row_ff       <= req_tdata[8:0];
         col_ff       <= req_tdata[18:9];
         px_ff        <= req_tdata[26:19];
         self_hit_ff  <= req_tdata[27];
         self_slot_ff <= req_tdata[32:28];
         nb_hit_ff    <= req_tdata[33];
         nb_slot_ff   <= req_tdata[38:34];
         dir_ff       <= req_tdata[41:39];
      end
      if (ctl.calc_addr) begin
         addr_ff     <= ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(col_ff);
         in_frame_ff <= (r_x < eff_h) && (c_x < eff_w);
         interior_ff <= (row_ff != '0) && (col_ff != '0) &&
                        (r_x + DIM_W'(1) < eff_h) && (c_x + DIM_W'(1) < eff_w);
         fg_ff       <= 1'b0;
      end
      if (ctl.calc_nb) begin
         nb_addr_ff <= nb_addr_in;
      end
      if (ctl.cmp) begin
         match_ff <= match_in;
      end
      if (ctl.count) begin
         fg_ff <= CMP_W'(cnt) < CMP_W'(cfg.min_matches);
      end
      if (ctl.out_set) begin
         rsp_fg_ff <= fg_ff;
      end
   end

   always_comb begin
      case (dir_ff)
         DIR_UL:  nb_addr_in = addr_ff - ADDR_W'(MAX_WIDTH) - ADDR_W'(1);
         DIR_U:   nb_addr_in = addr_ff - ADDR_W'(MAX_WIDTH);
         DIR_UR:  nb_addr_in = addr_ff - ADDR_W'(MAX_WIDTH) + ADDR_W'(1);
         DIR_DL:  nb_addr_in = addr_ff + ADDR_W'(MAX_WIDTH) - ADDR_W'(1);
         DIR_D:   nb_addr_in = addr_ff + ADDR_W'(MAX_WIDTH);
         DIR_DR:  nb_addr_in = addr_ff + ADDR_W'(MAX_WIDTH) + ADDR_W'(1);
         DIR_L:   nb_addr_in = addr_ff - ADDR_W'(1);
         DIR_R:   nb_addr_in = addr_ff + ADDR_W'(1);
         default: nb_addr_in = addr_ff;
      endcase
   end

   always_comb begin
      for (int k = 0; k < NUM_SAMPLES; k++) begin
         match_in[k] = ((rd[k] > px_ff) ? (rd[k] - px_ff) : (px_ff - rd[k]))
                       <= cfg.match_radius;
      end
   end

   assign cnt   = CNT_W'($countones(match_ff));
   assign waddr = ctl.nb_wr ? nb_addr_ff : addr_ff;

   for (genvar k = 0; k < NUM_SAMPLES; k++) begin : g_bank
      logic we;
      assign we = ctl.load_wr ||
                  (ctl.self_wr && self_slot_ff == SLOT_W'(k)) ||
                  (ctl.nb_wr && nb_slot_ff == SLOT_W'(k));
      vbs_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_bank (
         .clock (clock),
         .we    (we),
         .waddr (waddr),
         .wdata (px_ff),
         .raddr (addr_ff),
         .rdata (rd[k])
      );
   end

   assign sts.is_load  = (cmd_ff == CMD_LOAD);
   assign sts.in_frame = in_frame_ff;
   assign sts.interior = interior_ff;
   assign sts.fg       = fg_ff;
   assign sts.self_hit = self_hit_ff;
   assign sts.nb_hit   = nb_hit_ff;

   assign rsp_tdata = RSP_W'(rsp_fg_ff);
endmodule

FILE: rtl/vibe_background_subtractor_core.sv
// Single-channel ViBe background subtractor. Each req beat either loads a first-frame
// pixel into all NUM_SAMPLES sample slots (tuser 0) or classifies it (tuser 1); every
// beat yields one rsp beat, foreground in bit 0 (always 0 for loads and border pixels).
// Samples live in NUM_SAMPLES banks of MAX_WIDTH*MAX_HEIGHT bytes, read in parallel and
// never cleared: classify only pixels that were loaded. A load or border classify steps
// through address, bank read and output; an interior classify adds compare, count, self
// write and neighbor write on the shared bank write port; one item is in work at a time.
module vibe_background_subtractor_core #(
   parameter int NUM_SAMPLES = vbs_pkg::NUM_SAMPLES_DEF,
   parameter int MAX_WIDTH   = vbs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = vbs_pkg::MAX_HEIGHT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // row, col, pixel_value, self_update_hit, self_slot, neighbor_update_hit,
   // neighbor_slot, neighbor_direction
   input  logic [vbs_pkg::REQ_W-1:0]    req_tdata,
   // command
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // foreground
   output logic [vbs_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [vbs_pkg::PADDR_W-1:0]  csr_paddr,
   input  logic [vbs_pkg::PDATA_W-1:0]  csr_pwdata,
   output logic [vbs_pkg::PDATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import vbs_pkg::*;

   cfg_type cfg;
   ctl_type ctl;
   sts_type sts;

   vbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   vbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   vbs_dp #(
      .NUM_SAMPLES (NUM_SAMPLES),
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT)
   ) u_dp (
      .clock     (clock),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cfg       (cfg),
      .ctl       (ctl),
      .sts       (sts)
   );
endmodule

FILE: tb/tb.sv
module tb;
   import vbs_pkg::*;

   localparam int NSAMP = NUM_SAMPLES_DEF;
   localparam int MAXW  = MAX_WIDTH_DEF;
   localparam int MAXH  = MAX_HEIGHT_DEF;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_psel = 0;
   logic csr_penable = 0;
   logic csr_pwrite = 0;
   logic [PADDR_W-1:0] csr_paddr = '0;
   logic [PDATA_W-1:0] csr_pwdata = '0;
   logic [PDATA_W-1:0] csr_prdata;
   logic csr_pready;

   vibe_background_subtractor_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // background model copy and settings
   logic [7:0] samples[int];
   bit         loaded_px[int];
   logic [7:0] radius_q = 8'd20;
   logic [4:0] min_q    = 5'd2;
   logic [9:0] width_q  = 10'd640;
   logic [8:0] height_q = 9'd480;

   logic fg_expected[$];
   int   errors = 0;
   int   cycles = 0;
   bit   quiet = 0;

   function automatic int eff_w();
      return (width_q < MAXW) ? int'(width_q) : MAXW;
   endfunction

   function automatic int eff_h();
      return (height_q < MAXH) ? int'(height_q) : MAXH;
   endfunction

   function automatic bit is_interior(int r, int c);
      return r != 0 && c != 0 && r + 1 < eff_h() && c + 1 < eff_w();
   endfunction

   function automatic void put_sample(int r, int c, int slot, logic [7:0] v);
      if (slot < NSAMP && r < MAXH && c < MAXW)
         samples[(r * MAXW + c) * NSAMP + slot] = v;
   endfunction

   function automatic logic classify_pixel(logic cmd, int r, int c, logic [7:0] px,
                                           logic sh, int ss, logic nh, int ns,
                                           logic [DIR_W-1:0] dir);
      int cnt;
      int d;
      int nr;
      int nc;
      logic [7:0] s;
      if (cmd == CMD_LOAD) begin
         if (r < eff_h() && c < eff_w()) begin
            for (int k = 0; k < NSAMP; k++) put_sample(r, c, k, px);
            loaded_px[r * MAXW + c] = 1;
         end
         return 1'b0;
      end
      if (!is_interior(r, c)) return 1'b0;
      cnt = 0;
      for (int k = 0; k < NSAMP; k++) begin
         s = samples[(r * MAXW + c) * NSAMP + k];
         d = (s > px) ? int'(s) - int'(px) : int'(px) - int'(s);
         if (d <= radius_q) cnt++;
      end
      if (cnt < min_q) return 1'b1;
      if (sh) put_sample(r, c, ss, px);
      if (nh) begin
         nr = r;
         nc = c;
         case (dir)
            DIR_UL: begin nr = r - 1; nc = c - 1; end
            DIR_U:  nr = r - 1;
            DIR_UR: begin nr = r - 1; nc = c + 1; end
            DIR_DL: begin nr = r + 1; nc = c - 1; end
            DIR_D:  nr = r + 1;
            DIR_DR: begin nr = r + 1; nc = c + 1; end
            DIR_L:  nc = c - 1;
            default: nc = c + 1;
         endcase
         put_sample(nr, nc, ns, px);
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (fg_expected.size() == 0) begin
            $display("%0t: unexpected beat, expected none actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = fg_expected.pop_front();
            if (rsp_tdata !== {7'b0, want}) begin
               $display("%0t: foreground mismatch, expected %h actual %h",
                        $time, {7'b0, want}, rsp_tdata);
               errors++;
            end
         end
      end
   end

   // receiver stalls
   initial begin
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_RADIUS: radius_q = value[7:0];
         REG_MIN:    min_q = value[4:0];
         REG_WIDTH:  width_q = value[9:0];
         default:    height_q = value[8:0];
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (fg_expected.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic set_frame(int rad, int mm, int w, int h);
      drain();
      csr_write(REG_RADIUS, rad);
      csr_write(REG_MIN, mm);
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
   endtask

   task automatic send_pixel(logic cmd, int r, int c, logic [7:0] px, int sh, int ss,
                             int nh, int ns, logic [DIR_W-1:0] dir);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tuser <= cmd;
      req_tdata <= {6'b0, dir, ns[4:0], nh[0], ss[4:0], sh[0], px, c[9:0], r[8:0]};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fg_expected.push_back(classify_pixel(cmd, r, c, px, sh[0], ss, nh[0], ns, dir));
      @(negedge clock);
   endtask

   task automatic test_directed();
      set_frame(20, 2, 4, 4);
      send_pixel(CMD_LOAD, 1, 1, 8'd0, 0, 0, 0, 0, DIR_UL);
      send_pixel(CMD_LOAD, 1, 2, 8'd255, 0, 0, 0, 0, DIR_UL);
      send_pixel(CMD_LOAD, 2, 1, 8'd128, 0, 0, 0, 0, DIR_UL);
      send_pixel(CMD_LOAD, 2, 2, 8'd100, 0, 0, 0, 0, DIR_UL);
      send_pixel(CMD_LOAD, 511, 1023, 8'd77, 1, 31, 1, 31, DIR_R);
      send_pixel(CMD_CLASSIFY, 1, 1, 8'd0, 1, 31, 1, 31, DIR_UL);
      send_pixel(CMD_CLASSIFY, 1, 2, 8'd0, 1, 0, 1, 0, DIR_U);
      send_pixel(CMD_CLASSIFY, 1, 1, 8'd20, 1, 19, 1, 19, DIR_DR);
      send_pixel(CMD_CLASSIFY, 2, 2, 8'd120, 1, 0, 1, 5, DIR_UL);
      send_pixel(CMD_CLASSIFY, 1, 1, 8'd120, 0, 0, 0, 0, DIR_UL);
      send_pixel(CMD_CLASSIFY, 2, 1, 8'd128, 0, 3, 1, 4, DIR_UR);
      send_pixel(CMD_CLASSIFY, 1, 2, 8'd255, 1, 7, 1, 8, DIR_DL);
      send_pixel(CMD_CLASSIFY, 1, 2, 8'd240, 0, 0, 1, 9, DIR_D);
      send_pixel(CMD_CLASSIFY, 2, 2, 8'd100, 0, 0, 1, 10, DIR_L);
      send_pixel(CMD_CLASSIFY, 2, 1, 8'd130, 1, 20, 1, 20, DIR_R);
      send_pixel(CMD_CLASSIFY, 0, 0, 8'd255, 1, 1, 1, 1, DIR_R);
      send_pixel(CMD_CLASSIFY, 3, 3, 8'd255, 1, 1, 1, 1, DIR_R);
      send_pixel(CMD_CLASSIFY, 511, 1023, 8'd255, 1, 1, 1, 1, DIR_R);
      set_frame(255, 0, 4, 4);
      send_pixel(CMD_CLASSIFY, 1, 2, 8'd0, 1, 4, 1, 4, DIR_L);
      set_frame(0, 31, 4, 4);
      send_pixel(CMD_CLASSIFY, 1, 1, 8'd0, 1, 4, 1, 4, DIR_L);
   endtask

   task automatic test_random(int rad, int mm, int w, int h, int r0, int c0, int span,
                              int n);
      int r;
      int c;
      logic cmd;
      logic [7:0] px;
      set_frame(rad, mm, w, h);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            r = $urandom_range(0, 511);
            c = $urandom_range(0, 1023);
         end else begin
            r = r0 + $urandom_range(0, span - 1);
            c = c0 + $urandom_range(0, span - 1);
         end
         cmd = ($urandom_range(0, 4) == 0) ? CMD_LOAD : CMD_CLASSIFY;
         if (cmd == CMD_CLASSIFY && is_interior(r, c) && !loaded_px.exists(r * MAXW + c))
            cmd = CMD_LOAD;
         px = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'(110 + $urandom_range(0, 40));
         send_pixel(cmd, r, c, px, $urandom_range(0, 1), $urandom_range(0, 31),
                    $urandom_range(0, 1), $urandom_range(0, 31),
                    DIR_W'($urandom_range(0, 7)));
      end
   endtask

   task automatic test_tiny_frames();
      set_frame(20, 2, 2, 2);
      for (int i = 0; i < 10; i++)
         send_pixel(CMD_CLASSIFY, $urandom_range(0, 3), $urandom_range(0, 3), 8'd9,
                    1, 0, 1, 0, DIR_DR);
      test_random(255, 20, 3, 3, 0, 0, 4, 120);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_tiny_frames();
      test_random(20, 2, 8, 6, 0, 0, 9, 320);
      test_random(0, 1, 5, 4, 0, 0, 6, 200);
      test_random(40, 0, 16, 10, 0, 0, 17, 300);
      test_random(10, 31, 8, 8, 0, 0, 9, 150);
      test_random(30, 5, 1023, 511, 470, 630, 10, 300);
      quiet = 1;
      test_random(15, 3, 12, 9, 0, 0, 13, 300);
      drain();
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule

FILE: files.f
rtl/vbs_pkg.sv
rtl/vbs_ram.sv
rtl/vbs_csr.sv
rtl/vbs_ctrl.sv
rtl/vbs_dp.sv
rtl/vibe_background_subtractor_core.sv
tb/tb.sv
